// ----- hw/rtl/cabb_pkg.sv -----
// ----------------------------------------------------------------------------
// cabb_pkg - shared types and constants for the clipped alpha blend blitter
// Item payload structs, configuration struct, register map and clip limit.
// ----------------------------------------------------------------------------
`default_nettype none

package cabb_pkg;

    // Largest destination extent honored by the clip test
    localparam int MAX_DIM = 4096;
    localparam logic [17:0] DIM_LIMIT = 18'(MAX_DIM);

    localparam int ADDR_W = 5;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_POS_X         = 3'd0;
    localparam logic [2:0] REG_POS_Y         = 3'd1;
    localparam logic [2:0] REG_DEST_WIDTH    = 3'd2;
    localparam logic [2:0] REG_DEST_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd4;

    typedef struct packed {
        logic [31:0] src_pixel;
        logic [23:0] dst_pixel;
        logic [11:0] src_col;
        logic [11:0] src_row;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [23:0] out_pixel;
    } t_out;

    typedef struct packed {
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
        logic [12:0]        dest_width;
        logic [12:0]        dest_height;
        logic [12:0]        bitmap_height;
    } t_cfg;

    typedef struct packed {
        logic        keep;
        logic [11:0] x;
        logic [11:0] y;
    } t_place;

endpackage

`default_nettype wire

// ----- hw/rtl/clipped_alpha_blend_blit_top.sv -----
// Clipped alpha blend blitter.
// Pipeline: an accepted item moves from the input register to the result register,
// where it is offered on the output.
// Throughput: 1 item per cycle; both stages advance together when the output is taken.
// Reset: synchronous active low; clears both stage valids and loads register reset values.
// ----------------------------------------------------------------------------
// clipped_alpha_blend_blit_top - blitter top level
// APB register file, input register, placement and blend, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_alpha_blend_blit_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cabb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    input  wire cabb_pkg::t_in               i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output cabb_pkg::t_out                   o_out_data,
    input  wire logic                        i_out_stall
);
    import cabb_pkg::*;

    t_cfg   cfg;
    t_place place;
    logic [23:0] blend_pixel;

    logic   r_in_valid;
    t_in    r_in_data;
    logic   r_out_valid;
    t_out   r_out_data;
    t_out   n_out_data;

    logic   s1_free;
    logic   s2_free;

    cabb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cabb_place u_place (
        .i_cfg   (cfg),
        .i_col   (r_in_data.src_col),
        .i_row   (r_in_data.src_row),
        .o_place (place)
    );

    cabb_blend u_blend (
        .i_src   (r_in_data.src_pixel),
        .i_dst   (r_in_data.dst_pixel),
        .o_pixel (blend_pixel)
    );

    assign s2_free = !r_out_valid || !i_out_stall;
    assign s1_free = !r_in_valid || s2_free;

    assign o_in_stall  = !s1_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // clipped items pass the destination pixel back with zero coordinates
    always_comb begin
        n_out_data.write_enable = place.keep;
        n_out_data.dest_x       = place.keep ? place.x : 12'd0;
        n_out_data.dest_y       = place.keep ? place.y : 12'd0;
        n_out_data.out_pixel    = place.keep ? blend_pixel : r_in_data.dst_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_in_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (s2_free && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |->
            o_out_data.dest_x == 12'd0 && o_out_data.dest_y == 12'd0)
        else $error("clipped item carries nonzero coordinates");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && r_in_valid)
        else $error("input stalled while pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- hw/rtl/cabb_regs.sv -----
// ----------------------------------------------------------------------------
// cabb_regs - configuration register file
// APB-style write/read access to placement and clip registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cabb_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [cabb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output cabb_pkg::t_cfg                 o_cfg
);
    import cabb_pkg::*;

    t_cfg        r_cfg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x         <= '0;
            r_cfg.pos_y         <= '0;
            r_cfg.dest_width    <= '0;
            r_cfg.dest_height   <= '0;
            r_cfg.bitmap_height <= 13'd1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POS_X:         r_cfg.pos_x         <= pwdata[12:0];
                REG_POS_Y:         r_cfg.pos_y         <= pwdata[12:0];
                REG_DEST_WIDTH:    r_cfg.dest_width    <= pwdata[12:0];
                REG_DEST_HEIGHT:   r_cfg.dest_height   <= pwdata[12:0];
                REG_BITMAP_HEIGHT: r_cfg.bitmap_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POS_X:         prdata = {19'd0, r_cfg.pos_x};
            REG_POS_Y:         prdata = {19'd0, r_cfg.pos_y};
            REG_DEST_WIDTH:    prdata = {19'd0, r_cfg.dest_width};
            REG_DEST_HEIGHT:   prdata = {19'd0, r_cfg.dest_height};
            REG_BITMAP_HEIGHT: prdata = {19'd0, r_cfg.bitmap_height};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cabb_place.sv -----
// ----------------------------------------------------------------------------
// cabb_place - destination placement and clip test
// Maps column and bottom-up row to destination x/y and checks the bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module cabb_place (
    input  wire cabb_pkg::t_cfg i_cfg,
    input  wire logic [11:0]    i_col,
    input  wire logic [11:0]    i_row,
    output cabb_pkg::t_place    o_place
);
    import cabb_pkg::*;

    logic signed [13:0] x;
    logic signed [14:0] y;
    logic               row_ok;
    logic               x_ok;
    logic               y_ok;

    // x spans -4096..8190, y spans -8192..12285
    assign x = {i_cfg.pos_x[12], i_cfg.pos_x} + $signed({2'b00, i_col});
    assign y = {{2{i_cfg.pos_y[12]}}, i_cfg.pos_y}
             + $signed({2'b00, i_cfg.bitmap_height})
             - 15'sd1
             - $signed({3'b000, i_row});

    assign row_ok = {1'b0, i_row} < i_cfg.bitmap_height;
    assign x_ok   = !x[13] && (x[12:0] < i_cfg.dest_width)
                    && ({5'd0, x[12:0]} < DIM_LIMIT);
    assign y_ok   = !y[14] && (y[13:0] < {1'b0, i_cfg.dest_height})
                    && ({4'd0, y[13:0]} < DIM_LIMIT);

    assign o_place.keep = row_ok && x_ok && y_ok;
    assign o_place.x    = x[11:0];
    assign o_place.y    = y[11:0];

endmodule

`default_nettype wire

// ----- hw/rtl/cabb_blend.sv -----
// ----------------------------------------------------------------------------
// cabb_blend - non-premultiplied alpha blend of one RGB pixel
// Per channel: round-half-up of (D*(255-a) + S*a) / 255.
// ----------------------------------------------------------------------------
`default_nettype none

module cabb_blend (
    input  wire logic [31:0] i_src,
    input  wire logic [23:0] i_dst,
    output logic [23:0]      o_pixel
);
    logic [7:0] alpha;
    logic [7:0] alpha_inv;

    assign alpha     = i_src[31:24];
    assign alpha_inv = 8'd255 - alpha;

    always_comb begin
        logic [15:0] n;
        logic [16:0] m;
        logic [16:0] q;
        for (int c = 0; c < 3; c++) begin
            n = 16'(i_dst[c*8 +: 8] * alpha_inv) + 16'(i_src[c*8 +: 8] * alpha);
            // (2n+255)/510 == (n+127)/255; m stays below 65536
            m = {1'b0, n} + 17'd127;
            // exact divide by 255 for dividends below 65535, which covers every m here
            q = m + 17'd1 + {8'd0, m[16:8]};
            o_pixel[c*8 +: 8] = q[15:8];
        end
    end

endmodule

`default_nettype wire

// ----- tb/clipped_alpha_blend_blit_top_tb.sv -----
// ----------------------------------------------------------------------------
// clipped_alpha_blend_blit_top_tb - self-checking bench for the blitter
// Drives source/destination pixel items under random idling on both sides,
// programs the placement and clip registers over APB between phases, and
// checks every result against an in-bench model of placement, clipping and
// the rounded non-premultiplied blend.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_alpha_blend_blit_top_tb;

    import cabb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_BUSY    = 0;
    localparam int PHASE_SQUEEZE = 1;
    localparam int PHASE_CALM    = 2;

    class blit_scoreboard;
        t_cfg regs;
        t_out pending[$];
        int   fail_count;

        function new();
            regs = '0;
            regs.bitmap_height = 13'd1;
            fail_count = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [12:0] val);
            case (idx)
                REG_POS_X:         regs.pos_x = val;
                REG_POS_Y:         regs.pos_y = val;
                REG_DEST_WIDTH:    regs.dest_width = val;
                REG_DEST_HEIGHT:   regs.dest_height = val;
                REG_BITMAP_HEIGHT: regs.bitmap_height = val;
                default: ;
            endcase
        endfunction

        // round half up: floor((2*(D*(255-a) + S*a) + 255) / 510)
        function logic [7:0] mix_channel(logic [7:0] d, logic [7:0] s, logic [7:0] a);
            int unsigned sum;
            sum = 2 * (d * (255 - a) + s * a) + 255;
            return 8'(sum / 510);
        endfunction

        function t_out predict_blit(t_in px);
            t_out res;
            int   x, y, col, row, bh, w, h;
            col = px.src_col;
            row = px.src_row;
            bh  = regs.bitmap_height;
            w   = regs.dest_width;
            h   = regs.dest_height;
            if (w > MAX_DIM) w = MAX_DIM;
            if (h > MAX_DIM) h = MAX_DIM;
            x = $signed(regs.pos_x);
            y = $signed(regs.pos_y);
            x = x + col;
            // bitmap is stored bottom-up
            y = y + bh - 1 - row;
            res = '0;
            if (row < bh && x >= 0 && y >= 0 && x < w && y < h) begin
                res.write_enable = 1'b1;
                res.dest_x = x[11:0];
                res.dest_y = y[11:0];
                for (int c = 0; c < 3; c++) begin
                    res.out_pixel[8*c +: 8] = mix_channel(px.dst_pixel[8*c +: 8],
                                                          px.src_pixel[8*c +: 8],
                                                          px.src_pixel[31:24]);
                end
            end else begin
                res.out_pixel = px.dst_pixel;
            end
            return res;
        endfunction

        function void note_pixel(t_in px);
            pending.push_back(predict_blit(px));
        endfunction

        function void check_pixel(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $error("result %h with no pixel pending", got);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (got.write_enable !== want.write_enable) begin
                $error("write_enable: expected %0d, got %0d", want.write_enable,
                       got.write_enable);
                fail_count++;
            end
            if (got.dest_x !== want.dest_x) begin
                $error("dest_x: expected %0d, got %0d", want.dest_x, got.dest_x);
                fail_count++;
            end
            if (got.dest_y !== want.dest_y) begin
                $error("dest_y: expected %0d, got %0d", want.dest_y, got.dest_y);
                fail_count++;
            end
            if (got.out_pixel !== want.out_pixel) begin
                $error("out_pixel: expected %h, got %h", want.out_pixel, got.out_pixel);
                fail_count++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    t_in                 i_in_data;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out                o_out_data;
    logic                i_out_stall;

    blit_scoreboard sb;
    int             cycle_count = 0;
    int             in_gap_pct = 0;
    int             out_stall_pct = 0;
    bit             hold_req = 1'b0;

    clipped_alpha_blend_blit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("clipped_alpha_blend_blit_top_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_pixel(o_out_data);
        end
    end

    // result-side backpressure: random bursts, plus one long hold on request
    initial begin : result_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
                n = $urandom_range(1, 12);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_cfg geometry(int px, int py, int w, int h, int bh);
        t_cfg c;
        c.pos_x         = 13'(px);
        c.pos_y         = 13'(py);
        c.dest_width    = 13'(w);
        c.dest_height   = 13'(h);
        c.bitmap_height = 13'(bh);
        return c;
    endfunction

    function automatic t_in pixel_at(logic [31:0] s, logic [23:0] d, logic [11:0] col,
                                     logic [11:0] row);
        t_in p;
        p.src_pixel = s;
        p.dst_pixel = d;
        p.src_col   = col;
        p.src_row   = row;
        return p;
    endfunction

    function automatic t_in rand_pixel(int col_max, int row_max);
        t_in p;
        p.src_pixel = $urandom;
        p.dst_pixel = 24'($urandom);
        case ($urandom_range(0, 7))
            0: p.src_pixel[31:24] = 8'h00;
            1: p.src_pixel[31:24] = 8'hFF;
            default: ;
        endcase
        // mostly near the bitmap, sometimes anywhere in the field range
        if ($urandom_range(0, 4) == 0) begin
            p.src_col = 12'($urandom);
            p.src_row = 12'($urandom);
        end else begin
            p.src_col = 12'($urandom_range(0, col_max));
            p.src_row = 12'($urandom_range(0, row_max));
        end
        return p;
    endfunction

    function automatic int idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [12:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {19'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_geometry(input t_cfg c);
        apb_write(REG_POS_X, c.pos_x);
        apb_write(REG_POS_Y, c.pos_y);
        apb_write(REG_DEST_WIDTH, c.dest_width);
        apb_write(REG_DEST_HEIGHT, c.dest_height);
        apb_write(REG_BITMAP_HEIGHT, c.bitmap_height);
    endtask

    task automatic send_pixel(input t_in px);
        int n;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(px);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            n = $urandom_range(1, 12);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_window(output t_cfg c, output int col_max, output int row_max);
        int bw, bh, w, h;
        bw = $urandom_range(1, 48);
        bh = $urandom_range(1, 48);
        w  = $urandom_range(1, 64);
        h  = $urandom_range(1, 64);
        case ($urandom_range(0, 5))
            0: w = 0;
            1: h = 8191;
            default: ;
        endcase
        c = geometry(int'($urandom_range(0, 112)) - 48, int'($urandom_range(0, 112)) - 48,
                     w, h, bh);
        col_max = bw + 4;
        row_max = bh + 2;
    endtask

    task automatic random_phase(input t_cfg c, input int n, input int col_max,
                                input int row_max, input int mode);
        load_geometry(c);
        if (mode == PHASE_SQUEEZE) begin
            out_stall_pct = 0;
            hold_req = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            if (mode == PHASE_CALM) begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end else if (mode == PHASE_SQUEEZE && k < 40) begin
                in_gap_pct = 0;
            end else if (k % 20 == 0) begin
                in_gap_pct = idle_pct();
                out_stall_pct = idle_pct();
            end
            send_pixel(rand_pixel(col_max, row_max));
        end
        drain();
    endtask

    initial begin : stimulus
        t_cfg c;
        int   col_max, row_max;
        sb = new();
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_gap_pct = 25;
        out_stall_pct = 25;

        // reset geometry: zero-size destination clips everything
        send_pixel(pixel_at(32'hFFFFFFFF, 24'hABCDEF, 12'd0, 12'd0));
        send_pixel(pixel_at(32'h80123456, 24'h000000, 12'd0, 12'd1));
        send_pixel(pixel_at(32'h00FFFFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF));
        drain();

        // full-size destination, corners and blend extremes
        load_geometry(geometry(0, 0, 4096, 4096, 4096));
        send_pixel(pixel_at(32'hFFFFFFFF, 24'h000000, 12'hFFF, 12'h000));
        send_pixel(pixel_at(32'h00FFFFFF, 24'h123456, 12'h000, 12'hFFF));
        send_pixel(pixel_at(32'hFF000000, 24'hFFFFFF, 12'd7, 12'd9));
        send_pixel(pixel_at(32'h80FF00FF, 24'h00FF00, 12'd100, 12'd200));
        // rounding edge just below and just above one half
        send_pixel(pixel_at(32'h7F010101, 24'h000000, 12'd1, 12'd1));
        send_pixel(pixel_at(32'h80010101, 24'h000000, 12'd1, 12'd1));
        send_pixel(pixel_at(32'h00000000, 24'hFFFFFF, 12'hAAA, 12'h555));
        send_pixel(pixel_at(32'h01FFFFFF, 24'h000000, 12'h555, 12'hAAA));
        drain();

        // zero bitmap height: every row lies outside the bitmap
        load_geometry(geometry(100, 100, 8191, 4097, 0));
        send_pixel(pixel_at($urandom, 24'h5A5A5A, 12'd0, 12'd0));
        send_pixel(pixel_at($urandom, 24'hA5A5A5, 12'd10, 12'hFFF));
        drain();

        // oversized destination saturates to MAX_DIM
        apb_write(REG_BITMAP_HEIGHT, 13'd4096);
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd3995, 12'd100));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd3996, 12'd100));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd0, 12'd99));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd0, 12'hFFF));
        drain();

        // small window with a negative x offset, clip on every side
        load_geometry(geometry(-5, 5, 20, 10, 8));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd4, 12'd3));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd5, 12'd3));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd24, 12'd7));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd25, 12'd7));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd10, 12'd2));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd10, 12'd8));
        send_pixel(pixel_at($urandom, 24'($urandom), 12'd10, 12'd0));
        drain();

        random_window(c, col_max, row_max);
        random_phase(c, 100, col_max, row_max, PHASE_BUSY);
        random_phase(geometry(0, 0, 4096, 4096, 4096), 100, 4095, 4095, PHASE_SQUEEZE);
        random_phase(geometry(4095, -4096, 8191, 8191, 8191), 60, 8, 4095, PHASE_BUSY);
        random_window(c, col_max, row_max);
        random_phase(c, 110, col_max, row_max, PHASE_BUSY);
        random_window(c, col_max, row_max);
        random_phase(c, 110, col_max, row_max, PHASE_BUSY);
        random_window(c, col_max, row_max);
        random_phase(c, 100, col_max, row_max, PHASE_CALM);

        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending.size() == 0) begin
            $display("clipped_alpha_blend_blit_top_tb passed");
        end else begin
            $display("clipped_alpha_blend_blit_top_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
